// File: rtl/round_robin_ready_list_core_defines.svh
// assertion macros for the round robin ready list core
// used by the port checker; needs nothing else
`ifndef ROUND_ROBIN_READY_LIST_CORE_DEFINES_SVH
`define ROUND_ROBIN_READY_LIST_CORE_DEFINES_SVH

// same-cycle implication
`define RRRL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RRRL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rrrl_pkg.sv
// shared constants and types of the round robin ready list core
// no dependencies
package rrrl_pkg;

  localparam int unsigned ID_W        = 4;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned THREADS_DEF = 16;

  localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_B,
    ST_WR_1,
    ST_WR_2,
    ST_RESP
  } state_e;

endpackage

// File: rtl/rrrl_ram.sv
// generic single write port ram with registered read
// no dependencies
module rrrl_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/rrrl_link_table.sv
// link table: generic ram plus per-entry valid bits so that unwritten entries read as idle
// depends on rrrl_ram
module rrrl_link_table #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [DEPTH-1:0] vld_q, vld_d;
  logic             rd_vld_q, rd_vld_d;
  logic [WIDTH-1:0] ram_rdata;

  rrrl_ram #(
    .WIDTH(WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .re_i   (re_i),
    .raddr_i(raddr_i),
    .we_i   (we_i),
    .waddr_i(waddr_i),
    .wdata_i(wdata_i),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    vld_d    = vld_q;
    rd_vld_d = rd_vld_q;
    if (we_i) begin
      vld_d[waddr_i] = 1'b1;
    end
    if (re_i) begin
      rd_vld_d = vld_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      vld_q    <= vld_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  assign rdata_o = rd_vld_q ? ram_rdata : '0;

endmodule

// File: rtl/round_robin_ready_list_core.sv
// Round robin ready list core. Requests are insert, remove and advance; each gives one result.
// The ready ring lives in two link tables (next and prev), each one ram with one read and one
// write port and a registered read; entry 0 is the idle thread and holds head and tail. One
// request is worked on at a time: insert and remove go through two dependent read rounds and
// two write rounds on the single ports of the link tables (a failed one writes nothing and
// skips the second write round); advance and the unused code go through the two read rounds
// only. The result sits in an output register, so a new request is taken while a result still
// waits. After reset the tables read as idle at once through per-entry valid bits; there is no
// clearing pass.
// depends on rrrl_pkg and rrrl_link_table
module round_robin_ready_list_core #(
  parameter int unsigned THREADS = rrrl_pkg::THREADS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rrrl_pkg::FUNC_W-1:0] func_i,
  input  logic [rrrl_pkg::ID_W-1:0]   thread_id_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        ok_o,
  output logic [rrrl_pkg::ID_W-1:0]   run_thread_o
);

  localparam int unsigned AW = $clog2(THREADS);
  localparam int unsigned LW = (AW < rrrl_pkg::ID_W) ? AW : rrrl_pkg::ID_W;

  rrrl_pkg::state_e state_q, state_d;

  logic [rrrl_pkg::FUNC_W-1:0] func_q;
  logic [LW-1:0]               tid_q;
  logic                        id_ok_q;
  logic [rrrl_pkg::ID_W-1:0]   run_q;
  logic [LW-1:0]               cur_q, cur_d;
  logic [LW-1:0]               nt_q, pt_q;
  logic [LW-1:0]               v1_q, v1_d;
  logic                        ok_q, ok_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_ok_q;
  logic [rrrl_pkg::ID_W-1:0]   out_run_q;

  logic          accept, load, id_ok, op_ok;
  logic [LW-1:0] head, tail, ins_a;

  logic          nx_re, nx_we, pv_re, pv_we;
  logic [AW-1:0] nx_raddr, nx_waddr, pv_raddr, pv_waddr;
  logic [LW-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;

  rrrl_link_table #(
    .WIDTH(LW),
    .DEPTH(THREADS)
  ) u_next (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .re_i   (nx_re),
    .raddr_i(nx_raddr),
    .we_i   (nx_we),
    .waddr_i(nx_waddr),
    .wdata_i(nx_wdata),
    .rdata_o(nx_rdata)
  );

  rrrl_link_table #(
    .WIDTH(LW),
    .DEPTH(THREADS)
  ) u_prev (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .re_i   (pv_re),
    .raddr_i(pv_raddr),
    .we_i   (pv_we),
    .waddr_i(pv_waddr),
    .wdata_i(pv_wdata),
    .rdata_o(pv_rdata)
  );

  assign in_stall_o = (state_q != rrrl_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign load       = (state_q == rrrl_pkg::ST_RESP) && (!out_valid_q || !out_stall_i);
  assign id_ok      = (thread_id_i != '0) && (int'(thread_id_i) < THREADS);

  // second read round returns head and tail
  assign head  = nx_rdata;
  assign tail  = pv_rdata;
  assign ins_a = (head == '0) ? '0 : tail;

  always_comb begin
    op_ok = 1'b0;
    if (id_ok_q) begin
      case (func_q)
        rrrl_pkg::FUNC_INSERT: op_ok = (nt_q == '0);
        rrrl_pkg::FUNC_REMOVE: op_ok = (nt_q != '0);
        default:               op_ok = 1'b0;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rrrl_pkg::ST_IDLE: begin
        if (accept) state_d = rrrl_pkg::ST_RD_B;
      end
      rrrl_pkg::ST_RD_B: begin
        if (func_q == rrrl_pkg::FUNC_INSERT || func_q == rrrl_pkg::FUNC_REMOVE) begin
          state_d = rrrl_pkg::ST_WR_1;
        end else begin
          state_d = rrrl_pkg::ST_RESP;
        end
      end
      rrrl_pkg::ST_WR_1: begin
        state_d = op_ok ? rrrl_pkg::ST_WR_2 : rrrl_pkg::ST_RESP;
      end
      rrrl_pkg::ST_WR_2: state_d = rrrl_pkg::ST_RESP;
      rrrl_pkg::ST_RESP: begin
        if (load) state_d = rrrl_pkg::ST_IDLE;
      end
      default: state_d = rrrl_pkg::ST_IDLE;
    endcase
  end

  // table accesses and datapath
  always_comb begin
    nx_re    = 1'b0;
    pv_re    = 1'b0;
    nx_raddr = '0;
    pv_raddr = '0;
    nx_we    = 1'b0;
    pv_we    = 1'b0;
    nx_waddr = '0;
    pv_waddr = '0;
    nx_wdata = '0;
    pv_wdata = '0;
    cur_d    = cur_q;
    v1_d     = v1_q;
    ok_d     = ok_q;
    case (state_q)
      rrrl_pkg::ST_IDLE: begin
        if (accept) begin
          nx_re = 1'b1;
          pv_re = 1'b1;
          if (func_i == rrrl_pkg::FUNC_ADVANCE) begin
            nx_raddr = AW'(cur_q);
          end else if (id_ok) begin
            nx_raddr = AW'(thread_id_i);
            pv_raddr = AW'(thread_id_i);
          end
        end
      end
      rrrl_pkg::ST_RD_B: begin
        nx_re = 1'b1;
        pv_re = 1'b1;
        ok_d  = (func_q == rrrl_pkg::FUNC_ADVANCE);
        if (func_q == rrrl_pkg::FUNC_ADVANCE) begin
          cur_d = nx_rdata;
        end
      end
      rrrl_pkg::ST_WR_1: begin
        ok_d = op_ok;
        if (op_ok) begin
          nx_we = 1'b1;
          pv_we = 1'b1;
          if (func_q == rrrl_pkg::FUNC_INSERT) begin
            nx_waddr = AW'(ins_a);
            nx_wdata = tid_q;
            pv_waddr = AW'(tid_q);
            pv_wdata = tail;
            v1_d     = (ins_a == '0) ? tid_q : head;
          end else if (head == tid_q && tail == tid_q) begin
            nx_waddr = '0;
            nx_wdata = '0;
            pv_waddr = '0;
            pv_wdata = '0;
          end else if (head == tid_q) begin
            nx_waddr = '0;
            nx_wdata = nt_q;
            pv_waddr = AW'(nt_q);
            pv_wdata = tail;
          end else if (tail == tid_q) begin
            nx_waddr = AW'(pt_q);
            nx_wdata = head;
            pv_waddr = '0;
            pv_wdata = pt_q;
          end else begin
            nx_waddr = AW'(pt_q);
            nx_wdata = nt_q;
            pv_waddr = AW'(nt_q);
            pv_wdata = pt_q;
          end
        end
      end
      rrrl_pkg::ST_WR_2: begin
        nx_we    = 1'b1;
        pv_we    = 1'b1;
        nx_waddr = AW'(tid_q);
        if (func_q == rrrl_pkg::FUNC_INSERT) begin
          nx_wdata = v1_q;
          pv_waddr = '0;
          pv_wdata = tid_q;
        end else begin
          nx_wdata = '0;
          pv_waddr = AW'(tid_q);
          pv_wdata = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrrl_pkg::ST_IDLE;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= func_i;
      tid_q   <= LW'(thread_id_i);
      id_ok_q <= id_ok;
      run_q   <= rrrl_pkg::ID_W'(cur_q);
    end
    if (state_q == rrrl_pkg::ST_RD_B) begin
      nt_q <= nx_rdata;
      pt_q <= pv_rdata;
    end
    v1_q <= v1_d;
    ok_q <= ok_d;
    if (load) begin
      out_ok_q  <= ok_q;
      out_run_q <= run_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = out_ok_q;
  assign run_thread_o = out_run_q;

endmodule

// File: rtl/rrrl_checker.sv
// port checker for the round robin ready list core, bound to the top level
// depends on rrrl_pkg and round_robin_ready_list_core_defines.svh
`include "round_robin_ready_list_core_defines.svh"

module rrrl_checker #(
  parameter int unsigned THREADS = rrrl_pkg::THREADS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [rrrl_pkg::FUNC_W-1:0] func_i,
  input logic [rrrl_pkg::ID_W-1:0]   thread_id_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        ok_o,
  input logic [rrrl_pkg::ID_W-1:0]   run_thread_o
);

  logic unused_in;
  assign unused_in = ^{func_i, thread_id_i};

  `RRRL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `RRRL_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(ok_o) && $stable(run_thread_o), "stalled result changed")
  `RRRL_ASSERT_NXT(a_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "request taken while busy")
  `RRRL_ASSERT_IMP(a_run_range, clk_i, rst_ni, out_valid_o, int'(run_thread_o) < THREADS, "run thread out of range")

endmodule

bind round_robin_ready_list_core rrrl_checker #(
  .THREADS(THREADS)
) u_rrrl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .func_i      (func_i),
  .thread_id_i (thread_id_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .ok_o        (ok_o),
  .run_thread_o(run_thread_o)
);
